[rtl/kts_pkg.sv]
`timescale 1ns / 1ps

package kts_pkg;

  localparam int ID_W    = 32;
  localparam int LVL_W   = 8;
  localparam int SCORE_W = 64;
  localparam int VER_W   = 32;
  localparam int ST_W    = 3;
  localparam int FN_W    = 2;
  localparam int RIDX_W  = 4;

  // one table row; score holds two's complement bits
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LVL_W-1:0]   lvl;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic gt;
    logic eq;
    logic id_eq;
  } cmp_res_t;

  localparam logic [FN_W-1:0] FN_UPDATE   = 2'd0;
  localparam logic [FN_W-1:0] FN_ROLLOVER = 2'd1;
  localparam logic [FN_W-1:0] FN_READ     = 2'd2;

  localparam logic [ST_W-1:0] ST_INSERTED    = 3'd0;
  localparam logic [ST_W-1:0] ST_UPDATED     = 3'd1;
  localparam logic [ST_W-1:0] ST_REMOVED     = 3'd2;
  localparam logic [ST_W-1:0] ST_IGNORED     = 3'd3;
  localparam logic [ST_W-1:0] ST_ROLLED_OVER = 3'd4;
  localparam logic [ST_W-1:0] ST_READ_OK     = 3'd5;
  localparam logic [ST_W-1:0] ST_READ_EMPTY  = 3'd6;

  localparam logic CFG_DROP_EN  = 1'b0;
  localparam logic CFG_DROP_THR = 1'b1;

endpackage

[rtl/kts_cmp.sv]
`timescale 1ns / 1ps

// shared comparator: signed score order and id match
module kts_cmp (
  input  logic [kts_pkg::SCORE_W-1:0] a_score,
  input  logic [kts_pkg::SCORE_W-1:0] b_score,
  input  logic [kts_pkg::ID_W-1:0]    a_id,
  input  logic [kts_pkg::ID_W-1:0]    b_id,
  output kts_pkg::cmp_res_t           res
);

  assign res.gt    = $signed(a_score) > $signed(b_score);
  assign res.eq    = (a_score == b_score);
  assign res.id_eq = (a_id == b_id);

endmodule

[rtl/keyed_top_n_score_table.sv]
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// in_       sink       in_valid/in_stall   func, player_id, vip_level, score, list_select,
//                                          read_index, known_version
// out_      source     out_valid/out_stall status, version, up_to_date, player_id,
//                                          vip_level, score, current_count
// cfg_      sink       cfg_valid/cfg_ready index (0 drop_enable, 1 drop_threshold), data
//
// Update: id search (one row per cycle), decide, shift of the rows between new and old
//   slot, place, output; rollover goes straight to output; read goes through the read state.
//   The single read port of the table RAM is why one row is read per cycle.
// Reset clears control, counts, version and drop settings; rows are written before being read.
// A finished result waits in the output register while the next request is taken.
module keyed_top_n_score_table #(
  parameter int DEPTH = 16,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kts_pkg::FN_W-1:0]    in_func,
  input  logic [kts_pkg::ID_W-1:0]    in_player_id,
  input  logic [kts_pkg::LVL_W-1:0]   in_vip_level,
  input  logic signed [kts_pkg::SCORE_W-1:0] in_score,
  input  logic                        in_list_select,
  input  logic [kts_pkg::RIDX_W-1:0]  in_read_index,
  input  logic [kts_pkg::VER_W-1:0]   in_known_version,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kts_pkg::ST_W-1:0]    out_status,
  output logic [kts_pkg::VER_W-1:0]   out_version,
  output logic                        out_up_to_date,
  output logic [kts_pkg::ID_W-1:0]    out_player_id,
  output logic [kts_pkg::LVL_W-1:0]   out_vip_level,
  output logic signed [kts_pkg::SCORE_W-1:0] out_score,
  output logic [CW-1:0]               out_current_count,

  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [kts_pkg::SCORE_W-1:0] cfg_data
);

  localparam int AW    = IW + 1;
  localparam int MEM_D = 2 ** AW;
  localparam int XW    = (CW > kts_pkg::RIDX_W) ? CW : kts_pkg::RIDX_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_MOVE   = 7'b0001000,
    S_PLACE  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // two banks: current and previous, swapped on rollover
  kts_pkg::entry_t mem_r [MEM_D];
  kts_pkg::entry_t rdata_r;
  logic [AW-1:0]   rd_addr;
  logic            we;
  logic [AW-1:0]   wa;
  kts_pkg::entry_t wd;

  logic                     bank_r, bank_nxt;
  logic [CW-1:0]            cur_count_r, cur_count_nxt;
  logic [CW-1:0]            prev_count_r, prev_count_nxt;
  logic [kts_pkg::VER_W-1:0] version_r, version_nxt;
  logic                     drop_en_r;
  logic [kts_pkg::SCORE_W-1:0] drop_thr_r;

  logic [kts_pkg::ID_W-1:0]    it_id_r;
  logic [kts_pkg::LVL_W-1:0]   it_lvl_r;
  logic [kts_pkg::SCORE_W-1:0] it_score_r;
  logic                        it_sel_r;
  logic [kts_pkg::RIDX_W-1:0]  it_ridx_r;
  logic [kts_pkg::VER_W-1:0]   it_known_r;

  logic          found_r, found_nxt;
  logic [IW-1:0] f_idx_r, f_idx_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic          last_ge_r, last_ge_nxt;
  logic [IW-1:0] chk_r, chk_nxt;
  logic [IW-1:0] src_r, src_nxt;
  logic [IW-1:0] end_r, end_nxt;
  logic          dir_up_r, dir_up_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic [IW-1:0] wr_idx_r, wr_idx_nxt;

  logic [kts_pkg::ST_W-1:0] res_status_r, res_status_nxt;
  kts_pkg::entry_t          res_entry_r, res_entry_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_load;

  logic [kts_pkg::SCORE_W-1:0] cmp_a, cmp_b;
  kts_pkg::cmp_res_t           cmp;

  logic          in_acc;
  logic [IW-1:0] dec_f, dec_p;
  logic          dec_go;
  logic [CW-1:0] rd_cnt;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // scan compares row score against the request; decide compares against the threshold
  assign cmp_a = (state_r == S_DECIDE) ? it_score_r : rdata_r.score;
  assign cmp_b = (state_r == S_DECIDE) ? drop_thr_r : it_score_r;

  kts_cmp u_cmp (
    .a_score (cmp_a),
    .b_score (cmp_b),
    .a_id    (rdata_r.id),
    .b_id    (it_id_r),
    .res     (cmp)
  );

  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = (in_func == kts_pkg::FN_READ) ?
                {bank_r ^ in_list_select, IW'(in_read_index)} : {bank_r, IW'(0)};
    end else if (state_r == S_MOVE) begin
      rd_addr = {bank_r, src_r};
    end else begin
      rd_addr = {bank_r, chk_r + IW'(1)};
    end
  end

  always_comb begin
    we = 1'b0;
    wa = {bank_r, wr_idx_r};
    wd = rdata_r;
    if (wr_pend_r) begin
      we = 1'b1;
    end else if (state_r == S_PLACE) begin
      we = 1'b1;
      wa = {bank_r, p_r[IW-1:0]};
      wd = '{id: it_id_r, lvl: it_lvl_r, score: it_score_r};
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[rd_addr];
    if (we) begin
      mem_r[wa] <= wd;
    end
  end

  assign rd_cnt = it_sel_r ? prev_count_r : cur_count_r;

  always_comb begin
    state_nxt      = state_r;
    bank_nxt       = bank_r;
    cur_count_nxt  = cur_count_r;
    prev_count_nxt = prev_count_r;
    version_nxt    = version_r;
    found_nxt      = found_r;
    f_idx_nxt      = f_idx_r;
    p_nxt          = p_r;
    last_ge_nxt    = last_ge_r;
    chk_nxt        = chk_r;
    src_nxt        = src_r;
    end_nxt        = end_r;
    dir_up_nxt     = dir_up_r;
    wr_pend_nxt    = 1'b0;
    wr_idx_nxt     = wr_idx_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    dec_f          = f_idx_r;
    dec_p          = p_r[IW-1:0];
    dec_go         = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          chk_nxt       = '0;
          found_nxt     = 1'b0;
          p_nxt         = '0;
          last_ge_nxt   = 1'b0;
          res_entry_nxt = '0;
          unique case (in_func)
            kts_pkg::FN_UPDATE: begin
              state_nxt = (cur_count_r == '0) ? S_DECIDE : S_SCAN;
            end
            kts_pkg::FN_ROLLOVER: begin
              bank_nxt       = ~bank_r;
              prev_count_nxt = cur_count_r;
              cur_count_nxt  = '0;
              version_nxt    = version_r + 32'd1;
              res_status_nxt = kts_pkg::ST_ROLLED_OVER;
              state_nxt      = S_OUT;
            end
            kts_pkg::FN_READ: begin
              state_nxt = S_READ;
            end
            default: begin
              res_status_nxt = kts_pkg::ST_IGNORED;
              state_nxt      = S_OUT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // p counts rows that stay ahead: ties ahead of the match stay ahead,
        // ties behind it stay behind
        if (!found_r && cmp.id_eq) begin
          found_nxt = 1'b1;
          f_idx_nxt = chk_r;
        end else if (found_r ? cmp.gt : (cmp.gt || cmp.eq)) begin
          p_nxt = p_r + CW'(1);
        end
        last_ge_nxt = cmp.gt || cmp.eq;
        if (CW'(chk_r) + CW'(1) == cur_count_r) begin
          state_nxt = S_DECIDE;
        end else begin
          chk_nxt = chk_r + IW'(1);
        end
      end

      S_DECIDE: begin
        if (found_r) begin
          if (drop_en_r && !(cmp.gt || cmp.eq)) begin
            // removal: close the gap up to the old tail
            dec_p          = IW'(cur_count_r - CW'(1));
            cur_count_nxt  = cur_count_r - CW'(1);
            res_status_nxt = kts_pkg::ST_REMOVED;
          end else begin
            res_status_nxt = kts_pkg::ST_UPDATED;
          end
        end else if (cur_count_r < CW'(DEPTH)) begin
          dec_f          = cur_count_r[IW-1:0];
          cur_count_nxt  = cur_count_r + CW'(1);
          res_status_nxt = kts_pkg::ST_INSERTED;
        end else if (!last_ge_r) begin
          // full table, beats the last row
          dec_f          = IW'(DEPTH - 1);
          res_status_nxt = kts_pkg::ST_INSERTED;
        end else begin
          dec_go         = 1'b0;
          res_status_nxt = kts_pkg::ST_IGNORED;
        end

        if (dec_go) begin
          version_nxt = version_r + 32'd1;
          p_nxt       = CW'(dec_p);
          f_idx_nxt   = dec_f;
          if (dec_p < dec_f) begin
            dir_up_nxt = 1'b1;
            src_nxt    = dec_f - IW'(1);
            end_nxt    = dec_p;
            state_nxt  = S_MOVE;
          end else if (dec_p > dec_f) begin
            dir_up_nxt = 1'b0;
            src_nxt    = dec_f + IW'(1);
            end_nxt    = dec_p;
            state_nxt  = S_MOVE;
          end else begin
            state_nxt = S_PLACE;
          end
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_MOVE: begin
        // row read now is written one place towards the old slot next cycle
        wr_pend_nxt = 1'b1;
        wr_idx_nxt  = dir_up_r ? src_r + IW'(1) : src_r - IW'(1);
        if (src_r == end_r) begin
          state_nxt = S_PLACE;
        end else begin
          src_nxt = dir_up_r ? src_r - IW'(1) : src_r + IW'(1);
        end
      end

      S_PLACE: begin
        if (!wr_pend_r) begin
          state_nxt = S_OUT;
        end
      end

      S_READ: begin
        if (XW'(it_ridx_r) < XW'(rd_cnt)) begin
          res_status_nxt = kts_pkg::ST_READ_OK;
          res_entry_nxt  = rdata_r;
        end else begin
          res_status_nxt = kts_pkg::ST_READ_EMPTY;
          res_entry_nxt  = '0;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bank_r       <= 1'b0;
      cur_count_r  <= '0;
      prev_count_r <= '0;
      version_r    <= '0;
      wr_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      drop_en_r    <= 1'b0;
      drop_thr_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      bank_r       <= bank_nxt;
      cur_count_r  <= cur_count_nxt;
      prev_count_r <= prev_count_nxt;
      version_r    <= version_nxt;
      wr_pend_r    <= wr_pend_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          kts_pkg::CFG_DROP_EN:  drop_en_r  <= cfg_data[0];
          kts_pkg::CFG_DROP_THR: drop_thr_r <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r      <= found_nxt;
    f_idx_r      <= f_idx_nxt;
    p_r          <= p_nxt;
    last_ge_r    <= last_ge_nxt;
    chk_r        <= chk_nxt;
    src_r        <= src_nxt;
    end_r        <= end_nxt;
    dir_up_r     <= dir_up_nxt;
    wr_idx_r     <= wr_idx_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    if (in_acc) begin
      it_id_r    <= in_player_id;
      it_lvl_r   <= in_vip_level;
      it_score_r <= in_score;
      it_sel_r   <= in_list_select;
      it_ridx_r  <= in_read_index;
      it_known_r <= in_known_version;
    end
    if (out_load) begin
      out_status        <= res_status_r;
      out_version       <= version_r;
      out_up_to_date    <= (it_known_r >= version_r);
      out_player_id     <= res_entry_r.id;
      out_vip_level     <= res_entry_r.lvl;
      out_score         <= res_entry_r.score;
      out_current_count <= cur_count_r;
    end
  end

endmodule

[rtl/kts_chk.sv]
`timescale 1ns / 1ps

module kts_chk #(
  parameter int DEPTH = 16,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [kts_pkg::ST_W-1:0]    out_status,
  input logic [kts_pkg::ID_W-1:0]    out_player_id,
  input logic [kts_pkg::LVL_W-1:0]   out_vip_level,
  input logic [kts_pkg::SCORE_W-1:0] out_score,
  input logic [CW-1:0]               out_current_count
);

  // a taken request makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_valid && !in_stall) |=> in_stall)
    else $error("request taken but block not busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_current_count)))
    else $error("stalled result changed");

  a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != kts_pkg::ST_READ_OK) |->
      (out_player_id == '0 && out_vip_level == '0 && out_score == '0))
    else $error("entry fields set on a result that is not a read");

  a_roll_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == kts_pkg::ST_ROLLED_OVER) |-> (out_current_count == '0))
    else $error("current table not empty after rollover");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_current_count <= CW'(DEPTH)))
    else $error("entry count above table depth");

endmodule

bind keyed_top_n_score_table kts_chk #(.DEPTH(DEPTH)) u_kts_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_player_id     (out_player_id),
  .out_vip_level     (out_vip_level),
  .out_score         (out_score),
  .out_current_count (out_current_count)
);

[sim/keyed_top_n_score_table_tb.sv]
`timescale 1ns / 1ps

module keyed_top_n_score_table_tb;

  localparam int DEPTH = 16;
  localparam int POOL = 24;
  localparam int PHASES = 5;
  localparam int PER_PHASE = 276;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES = 1_200_000;
  localparam logic [kts_pkg::FN_W-1:0] FN_UNUSED = 2'd3;
  localparam logic [kts_pkg::SCORE_W-1:0] SCORE_MIN = 64'h8000_0000_0000_0000;
  localparam logic [kts_pkg::SCORE_W-1:0] SCORE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [kts_pkg::FN_W-1:0]    func;
    logic [kts_pkg::ID_W-1:0]    pid;
    logic [kts_pkg::LVL_W-1:0]   lvl;
    logic [kts_pkg::SCORE_W-1:0] score;
    logic                        sel;
    logic [kts_pkg::RIDX_W-1:0]  ridx;
    logic [kts_pkg::VER_W-1:0]   known;
  } req_t;

  typedef struct packed {
    logic [kts_pkg::ST_W-1:0]    status;
    logic [kts_pkg::VER_W-1:0]   ver;
    logic                        fresh;
    logic [kts_pkg::ID_W-1:0]    pid;
    logic [kts_pkg::LVL_W-1:0]   lvl;
    logic [kts_pkg::SCORE_W-1:0] score;
    logic [4:0]                  cnt;
  } rank_res_t;

  // Tracks the ranking tables alongside the block and holds the results it owes
  class leaderboard_check;
    kts_pkg::entry_t cur_tab[DEPTH];
    kts_pkg::entry_t prev_tab[DEPTH];
    int cur_n = 0;
    int prev_n = 0;
    logic [kts_pkg::VER_W-1:0] ver = '0;
    logic drop_en = 1'b0;
    logic [kts_pkg::SCORE_W-1:0] drop_thr = '0;
    rank_res_t pending_results[$];
    int errors = 0;
    int seen = 0;
    int tally[8];

    function new();
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function void set_reg(logic idx, logic [kts_pkg::SCORE_W-1:0] data);
      if (idx == kts_pkg::CFG_DROP_EN) drop_en = data[0];
      else drop_thr = data;
    endfunction

    // stable re-placement: equal scores never pass each other
    function void resettle(int i);
      kts_pkg::entry_t t;
      while (i > 0 && $signed(cur_tab[i-1].score) < $signed(cur_tab[i].score)) begin
        t = cur_tab[i-1];
        cur_tab[i-1] = cur_tab[i];
        cur_tab[i] = t;
        i--;
      end
      while (i + 1 < cur_n && $signed(cur_tab[i+1].score) > $signed(cur_tab[i].score)) begin
        t = cur_tab[i+1];
        cur_tab[i+1] = cur_tab[i];
        cur_tab[i] = t;
        i++;
      end
    endfunction

    function void note_request(req_t r);
      rank_res_t e;
      kts_pkg::entry_t row;
      int hit;
      int cnt;
      e = '0;
      e.status = kts_pkg::ST_IGNORED;
      row = '{id: r.pid, lvl: r.lvl, score: r.score};
      case (r.func)
        kts_pkg::FN_UPDATE: begin
          hit = cur_n;
          for (int i = cur_n - 1; i >= 0; i--)
            if (cur_tab[i].id == r.pid) hit = i;
          if (hit < cur_n) begin
            if (drop_en && $signed(r.score) < $signed(drop_thr)) begin
              for (int j = hit; j + 1 < cur_n; j++) cur_tab[j] = cur_tab[j+1];
              cur_n--;
              e.status = kts_pkg::ST_REMOVED;
            end else begin
              cur_tab[hit] = row;
              resettle(hit);
              e.status = kts_pkg::ST_UPDATED;
            end
            ver++;
          end else if (cur_n < DEPTH) begin
            cur_tab[cur_n] = row;
            cur_n++;
            resettle(cur_n - 1);
            e.status = kts_pkg::ST_INSERTED;
            ver++;
          end else if ($signed(cur_tab[DEPTH-1].score) < $signed(r.score)) begin
            // full table: newcomer displaces the tail
            cur_tab[DEPTH-1] = row;
            resettle(DEPTH - 1);
            e.status = kts_pkg::ST_INSERTED;
            ver++;
          end
        end
        kts_pkg::FN_ROLLOVER: begin
          prev_tab = cur_tab;
          prev_n = cur_n;
          cur_n = 0;
          ver++;
          e.status = kts_pkg::ST_ROLLED_OVER;
        end
        kts_pkg::FN_READ: begin
          cnt = r.sel ? prev_n : cur_n;
          if (r.ridx < cnt) begin
            row = r.sel ? prev_tab[r.ridx] : cur_tab[r.ridx];
            e.pid = row.id;
            e.lvl = row.lvl;
            e.score = row.score;
            e.status = kts_pkg::ST_READ_OK;
          end else begin
            e.status = kts_pkg::ST_READ_EMPTY;
          end
        end
        default: ;
      endcase
      e.ver = ver;
      e.fresh = (r.known >= ver);
      e.cnt = 5'(cur_n);
      pending_results = {pending_results, e};
    endfunction

    function void compare(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: %s expected %0h got %0h", seen, what, want, got);
      end
    endfunction

    function void check_result(rank_res_t got);
      rank_res_t want;
      seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: nothing expected, got status %0d", seen, got.status);
        return;
      end
      want = pending_results.pop_front();
      tally[want.status]++;
      compare("status", 64'(want.status), 64'(got.status));
      compare("version", 64'(want.ver), 64'(got.ver));
      compare("up_to_date", 64'(want.fresh), 64'(got.fresh));
      compare("player_id", 64'(want.pid), 64'(got.pid));
      compare("vip_level", 64'(want.lvl), 64'(got.lvl));
      compare("score", want.score, got.score);
      compare("current_count", 64'(want.cnt), 64'(got.cnt));
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [kts_pkg::FN_W-1:0] in_func = '0;
  logic [kts_pkg::ID_W-1:0] in_player_id = '0;
  logic [kts_pkg::LVL_W-1:0] in_vip_level = '0;
  logic signed [kts_pkg::SCORE_W-1:0] in_score = '0;
  logic in_list_select = 1'b0;
  logic [kts_pkg::RIDX_W-1:0] in_read_index = '0;
  logic [kts_pkg::VER_W-1:0] in_known_version = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [kts_pkg::ST_W-1:0] out_status;
  logic [kts_pkg::VER_W-1:0] out_version;
  logic out_up_to_date;
  logic [kts_pkg::ID_W-1:0] out_player_id;
  logic [kts_pkg::LVL_W-1:0] out_vip_level;
  logic signed [kts_pkg::SCORE_W-1:0] out_score;
  logic [4:0] out_current_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [kts_pkg::SCORE_W-1:0] cfg_data = '0;

  logic rx_hold = 1'b0;
  int cycle_count = 0;
  logic [kts_pkg::ID_W-1:0] id_pool[POOL];
  leaderboard_check board = new();

  keyed_top_n_score_table #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_player_id(in_player_id), .in_vip_level(in_vip_level), .in_score(in_score),
    .in_list_select(in_list_select), .in_read_index(in_read_index),
    .in_known_version(in_known_version),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_version(out_version), .out_up_to_date(out_up_to_date),
    .out_player_id(out_player_id), .out_vip_level(out_vip_level), .out_score(out_score),
    .out_current_count(out_current_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL keyed_top_n_score_table");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(rank_res_t'{status: out_status, ver: out_version,
                                     fresh: out_up_to_date, pid: out_player_id,
                                     lvl: out_vip_level, score: out_score,
                                     cnt: out_current_count});
  end

  // result side back-pressure; one long hold so the block backs up into its input
  initial begin : rx_pacing
    int run;
    bit held;
    held = 0;
    forever begin
      @(posedge clk);
      if (rx_hold && !held) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b0;
        run = $urandom_range(1, 40);
        repeat (run - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        run = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        repeat (run - 1) @(posedge clk);
      end
    end
  end

  task automatic send_req(req_t r);
    int k;
    int gap;
    in_valid <= 1'b1;
    in_func <= r.func;
    in_player_id <= r.pid;
    in_vip_level <= r.lvl;
    in_score <= r.score;
    in_list_select <= r.sel;
    in_read_index <= r.ridx;
    in_known_version <= r.known;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(r);
    k = $urandom_range(0, 19);
    gap = (k < 11) ? 0 : (k < 18) ? $urandom_range(1, 3) : $urandom_range(15, 50);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // both registers in one burst, only once every result is back
  task automatic set_drop(logic en, logic [kts_pkg::SCORE_W-1:0] thr);
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= kts_pkg::CFG_DROP_EN;
    cfg_data <= {63'd0, en};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(kts_pkg::CFG_DROP_EN, {63'd0, en});
    cfg_index <= kts_pkg::CFG_DROP_THR;
    cfg_data <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(kts_pkg::CFG_DROP_THR, thr);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t mk(logic [kts_pkg::FN_W-1:0] f, logic [kts_pkg::ID_W-1:0] p,
                              logic [kts_pkg::LVL_W-1:0] l, logic [kts_pkg::SCORE_W-1:0] s,
                              logic ls, logic [kts_pkg::RIDX_W-1:0] ri,
                              logic [kts_pkg::VER_W-1:0] kv);
    return '{func: f, pid: p, lvl: l, score: s, sel: ls, ridx: ri, known: kv};
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int k;
    int cnt;
    longint s;
    k = $urandom_range(0, 99);
    r.func = (k < 55) ? kts_pkg::FN_UPDATE : (k < 58) ? kts_pkg::FN_ROLLOVER :
             (k < 98) ? kts_pkg::FN_READ : FN_UNUSED;
    r.pid = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, POOL - 1)];
    r.lvl = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: r.score = SCORE_MIN;
      1: r.score = SCORE_MAX;
      2: r.score = $urandom_range(0, 1) ? '0 : '1;
      3, 4, 5, 6: begin
        // narrow band so ties and threshold edges come up often
        s = $urandom_range(0, 40);
        s = s - 20;
        r.score = s;
      end
      default: r.score = {$urandom, $urandom};
    endcase
    r.sel = 1'($urandom_range(0, 1));
    cnt = r.sel ? board.prev_n : board.cur_n;
    if (cnt > 0 && $urandom_range(0, 1)) r.ridx = 4'($urandom_range(0, cnt - 1));
    else r.ridx = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0: r.known = $urandom;
      1: r.known = board.ver;
      2: r.known = board.ver + 1;
      default: r.known = board.ver - 1;
    endcase
    return r;
  endfunction

  initial begin : main
    req_t plan[$];
    logic phase_en[PHASES];
    logic [kts_pkg::SCORE_W-1:0] phase_thr[PHASES];
    int total;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no dropping
    plan = {plan, mk(kts_pkg::FN_READ, '0, '0, '0, 1'b0, 4'd0, 32'd0)};
    plan = {plan, mk(kts_pkg::FN_READ, '0, '0, '0, 1'b1, 4'd15, '1)};
    plan = {plan, mk(FN_UNUSED, '1, '1, '1, 1'b1, 4'd15, '1)};
    plan = {plan, mk(kts_pkg::FN_UPDATE, 32'd0, 8'd0, SCORE_MAX, 1'b0, 4'd0, 32'd0)};
    plan = {plan, mk(kts_pkg::FN_UPDATE, '1, '1, SCORE_MIN, 1'b1, 4'd15, '1)};
    plan = {plan, mk(kts_pkg::FN_UPDATE, 32'd5, 8'h5A, 64'd0, 1'b0, 4'd0, 32'd2)};
    plan = {plan, mk(kts_pkg::FN_UPDATE, 32'd6, 8'hA5, 64'd0, 1'b0, 4'd0, 32'd4)};
    plan = {plan, mk(kts_pkg::FN_UPDATE, 32'd5, 8'd1, 64'd0, 1'b0, 4'd0, 32'd5)};
    plan = {plan, mk(kts_pkg::FN_UPDATE, 32'd0, 8'd2, '1, 1'b0, 4'd0, 32'd6)};
    for (int i = 0; i < 4; i++)
      plan = {plan, mk(kts_pkg::FN_READ, '0, '0, '0, 1'b0, 4'(i), 32'd6)};
    plan = {plan, mk(kts_pkg::FN_READ, '0, '0, '0, 1'b0, 4'd15, 32'd5)};
    plan = {plan, mk(kts_pkg::FN_ROLLOVER, '0, '0, '0, 1'b0, 4'd0, 32'd7)};
    plan = {plan, mk(kts_pkg::FN_READ, '0, '0, '0, 1'b1, 4'd3, 32'd7)};
    plan = {plan, mk(kts_pkg::FN_READ, '0, '0, '0, 1'b0, 4'd0, 32'd7)};
    foreach (plan[i]) send_req(plan[i]);

    // dropping on, threshold 10: low score on a known id removes it
    set_drop(1'b1, 64'd10);
    plan.delete();
    plan = {plan, mk(kts_pkg::FN_UPDATE, 32'd1, 8'd3, 64'd20, 1'b0, 4'd0, 32'd0)};
    plan = {plan, mk(kts_pkg::FN_UPDATE, 32'd1, 8'd3, 64'd5, 1'b0, 4'd0, 32'd0)};
    plan = {plan, mk(kts_pkg::FN_UPDATE, 32'd2, 8'd4, 64'd3, 1'b0, 4'd0, 32'd0)};
    plan = {plan, mk(kts_pkg::FN_UPDATE, 32'd2, 8'd4, 64'd10, 1'b0, 4'd0, '1)};
    plan = {plan, mk(kts_pkg::FN_UPDATE, 32'd2, 8'd4, 64'd9, 1'b0, 4'd0, '1)};
    plan = {plan, mk(kts_pkg::FN_READ, '0, '0, '0, 1'b1, 4'd0, '1)};
    foreach (plan[i]) send_req(plan[i]);

    phase_en = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
    phase_thr = '{-64'sd5, 64'd3, SCORE_MIN, SCORE_MAX, {$urandom, $urandom}};
    for (int p = 0; p < PHASES; p++) begin
      set_drop(phase_en[p], phase_thr[p]);
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < POOL; i++) id_pool[i] = $urandom;
      if (p == 0) rx_hold <= 1'b1;
      for (int n = 0; n < PER_PHASE; n++) send_req(rand_req());
    end

    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);

    total = board.seen;
    $display("covered %0d requests: %0d inserted, %0d updated, %0d removed, %0d ignored",
             total, board.tally[kts_pkg::ST_INSERTED], board.tally[kts_pkg::ST_UPDATED],
             board.tally[kts_pkg::ST_REMOVED], board.tally[kts_pkg::ST_IGNORED]);
    $display("  %0d rollovers, %0d reads of an entry, %0d reads past the count",
             board.tally[kts_pkg::ST_ROLLED_OVER], board.tally[kts_pkg::ST_READ_OK],
             board.tally[kts_pkg::ST_READ_EMPTY]);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("PASS keyed_top_n_score_table");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("FAIL keyed_top_n_score_table");
    end
    $finish;
  end

endmodule

[keyed_top_n_score_table.f]
rtl/kts_pkg.sv
rtl/kts_cmp.sv
rtl/keyed_top_n_score_table.sv
rtl/kts_chk.sv
sim/keyed_top_n_score_table_tb.sv
